FILE: sv/sps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

   localparam int unsigned POS_W = 24;
   localparam int unsigned PTR_W = 3;
   localparam int unsigned DIST_SHIFT = 7;

   typedef enum logic {
      REQ_SET_TARGET = 1'b0,
      REQ_TICK       = 1'b1
   } req_code_type;

   typedef enum logic {
      CSR_REVERSE_DIRECTION = 1'b0,
      CSR_HALF_STEP_MODE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [3:0]             coil_pattern;
      logic signed [POS_W-1:0] position;
      logic [2:0]             steps_moved;
      logic                   at_target;
   } result_type;

   function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hC;
         3'd6:    pat = 4'h8;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   function automatic logic [3:0] full_step_pattern(input logic [1:0] idx);
      logic [3:0] pat;
      case (idx)
         2'd0:    pat = 4'h3;
         2'd1:    pat = 4'h6;
         2'd2:    pat = 4'hC;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

FILE: sv/stepper_position_sequencer.sv
// Stepper position sequencer: drives a four-coil stepper toward a target.
// Input channel (req_valid / req_stall): req_type 0 loads a new signed
// target and yields no response; req_type 1 is a tick and yields exactly one
// response on the rsp channel (rsp_valid / rsp_stall) with the coil pattern,
// new position, steps taken (0 when already at the target) and the at-target flag.
// Configuration: csr_write_enable with csr_index 0 sets reverse direction,
// index 1 sets half-step mode; write only while the block is idle.
// Output: a tick's response is registered in the response register, or in the skid register while it is stalled.
// Throughput: one transaction per cycle while req_stall is low; the step burst is
// computed in one pass from the position and target registers.
// Stall: the response register is backed by a one-entry skid register, so
// the input keeps accepting while a response waits; req_stall rises only
// once the skid entry is occupied and falls when the response drains.
// Reset: synchronous; clears position, target and phase pointer to zero,
// reverse to 0, half-step mode to 1, and empties the response buffers.
`timescale 1ns / 1ps
`default_nettype none
module stepper_position_sequencer
   import sps_pkg::*;
#(
   parameter int unsigned MAX_BURST = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_index,
   input  wire logic                    csr_data,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_type,
   input  wire logic signed [POS_W-1:0] req_target_position,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [3:0]                   rsp_coil_pattern,
   output logic signed [POS_W-1:0]      rsp_position,
   output logic [2:0]                   rsp_steps_moved,
   output logic                         rsp_at_target
);

   logic       accept;
   logic       new_valid;
   result_type new_result;

   logic       out_valid_ff;
   result_type out_ff;
   logic       skid_valid_ff;
   result_type skid_ff;
   logic       out_free;

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   sps_core #(
      .MAX_BURST(MAX_BURST)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .accept              (accept),
      .req_type            (req_type),
      .req_target_position (req_target_position),
      .result_valid        (new_valid),
      .result              (new_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= new_valid;
            end
         end else if (new_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : new_result;
      end else if (new_valid) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_coil_pattern = out_ff.coil_pattern;
   assign rsp_position = out_ff.position;
   assign rsp_steps_moved = out_ff.steps_moved;
   assign rsp_at_target = out_ff.at_target;

endmodule
`default_nettype wire

FILE: sv/sps_core.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_core
   import sps_pkg::*;
#(
   parameter int unsigned MAX_BURST = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_index,
   input  wire logic                    csr_data,
   input  wire logic                    accept,
   input  wire logic                    req_type,
   input  wire logic signed [POS_W-1:0] req_target_position,
   output logic                         result_valid,
   output result_type                   result
);

   localparam int unsigned BURST_W = $clog2(MAX_BURST + 1);
   localparam int unsigned DIST_W = POS_W + 1;
   localparam int unsigned QUOT_W = DIST_W - DIST_SHIFT;
   localparam logic [QUOT_W-1:0] BURST_MAX_Q = QUOT_W'(MAX_BURST);
   localparam logic [BURST_W-1:0] BURST_MAX_N = BURST_W'(MAX_BURST);

   logic                    reverse_ff;
   logic                    half_step_ff;
   logic signed [POS_W-1:0] target_ff;
   logic signed [POS_W-1:0] position_ff;
   logic [PTR_W-1:0]        pointer_ff;

   logic signed [POS_W-1:0] position_in;
   logic [PTR_W-1:0]        pointer_in;

   logic [DIST_W-1:0]  diff;
   logic [DIST_W-1:0]  distance;
   logic [QUOT_W-1:0]  quot;
   logic               at_target;
   logic               up;
   logic               ptr_up;
   logic [BURST_W-1:0] n;
   logic [7:0]         n_wide;
   logic [PTR_W-1:0]   n3;
   logic [PTR_W-1:0]   ptr_sum;
   logic [PTR_W-1:0]   ptr_mask;
   logic               is_tick;

   assign is_tick = (req_type == REQ_TICK);

   always_comb begin
      diff = {target_ff[POS_W-1], target_ff} - {position_ff[POS_W-1], position_ff};
      at_target = (diff == '0);
      up = !diff[DIST_W-1] && !at_target;
      distance = up ? diff : (DIST_W'(0) - diff);
      quot = distance[DIST_W-1:DIST_SHIFT];
      if (quot == '0) begin
         n = BURST_W'(1);
      end else if (quot >= BURST_MAX_Q) begin
         n = BURST_MAX_N;
      end else begin
         n = quot[BURST_W-1:0];
      end
      n_wide = 8'(n);
      n3 = n_wide[PTR_W-1:0];
      ptr_up = up != reverse_ff;
      ptr_mask = half_step_ff ? 3'b111 : 3'b011;
      ptr_sum = ptr_up ? (pointer_ff + n3) : (pointer_ff - n3);
      if (at_target) begin
         position_in = position_ff;
         pointer_in = pointer_ff;
      end else begin
         position_in = up ? (position_ff + POS_W'(n_wide)) : (position_ff - POS_W'(n_wide));
         pointer_in = ptr_sum & ptr_mask;
      end

      result_valid = accept && is_tick;
      result.position = position_in;
      result.at_target = at_target;
      if (at_target) begin
         result.coil_pattern = 4'h0;
         result.steps_moved = 3'd0;
      end else begin
         result.coil_pattern = half_step_ff ? half_step_pattern(pointer_in)
                                            : full_step_pattern(pointer_in[1:0]);
         result.steps_moved = (n_wide > 8'd7) ? 3'd7 : n_wide[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         half_step_ff <= 1'b1;
         target_ff <= '0;
         position_ff <= '0;
         pointer_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_REVERSE_DIRECTION: reverse_ff <= csr_data;
               CSR_HALF_STEP_MODE:    half_step_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            if (is_tick) begin
               position_ff <= position_in;
               pointer_ff <= pointer_in;
            end else begin
               target_ff <= req_target_position;
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import sps_pkg::*;

   localparam int unsigned MAX_STEPS = 4;
   localparam int unsigned PHASE_ITEMS = 290;

   class motion_tracker;
      logic signed [POS_W-1:0] target;
      logic signed [POS_W-1:0] position;
      logic [PTR_W-1:0]        pointer;
      logic                    reverse;
      logic                    half_step;
      int unsigned             burst_limit;
      int unsigned             mismatches;
      result_type              pending[$];
      logic [3:0]              half_coils[8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                  4'h4, 4'hC, 4'h8, 4'h9};
      logic [3:0]              full_coils[4] = '{4'h3, 4'h6, 4'hC, 4'h9};

      function new(int unsigned limit);
         burst_limit = limit;
         mismatches = 0;
         target = '0;
         position = '0;
         pointer = '0;
         reverse = 1'b0;
         half_step = 1'b1;
      endfunction

      function void set_reg(csr_index_type idx, logic val);
         if (idx == CSR_REVERSE_DIRECTION) begin
            reverse = val;
         end else begin
            half_step = val;
         end
      endfunction

      function void take_request(req_code_type kind, logic signed [POS_W-1:0] tgt);
         result_type  want;
         logic        up;
         logic        fwd;
         int          distance;
         int unsigned n;
         logic [2:0]  mask;
         if (kind == REQ_SET_TARGET) begin
            target = tgt;
            return;
         end
         if (position == target) begin
            want.coil_pattern = 4'h0;
            want.position = position;
            want.steps_moved = 3'd0;
            want.at_target = 1'b1;
         end else begin
            up = target > position;
            distance = up ? int'(target) - int'(position) : int'(position) - int'(target);
            n = distance / 128;
            if (n < 1) n = 1;
            if (n > burst_limit) n = burst_limit;
            if (n > distance) n = distance;
            position = up ? position + POS_W'(n) : position - POS_W'(n);
            mask = half_step ? 3'd7 : 3'd3;
            fwd = up ^ reverse;
            pointer = fwd ? (pointer + n[2:0]) & mask : (pointer - n[2:0]) & mask;
            want.coil_pattern = half_step ? half_coils[pointer] : full_coils[pointer[1:0]];
            want.position = position;
            want.steps_moved = (n > 7) ? 3'd7 : n[2:0];
            want.at_target = 1'b0;
         end
         pending.push_back(want);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_response(logic [3:0] coils, logic signed [POS_W-1:0] pos,
                          logic [2:0] steps, logic at);
         result_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with no tick outstanding");
            return;
         end
         want = pending.pop_front();
         if (coils !== want.coil_pattern)
            report_mismatch($sformatf("coil_pattern got %h want %h", coils, want.coil_pattern));
         if (pos !== want.position)
            report_mismatch($sformatf("position got %0d want %0d", pos, want.position));
         if (steps !== want.steps_moved)
            report_mismatch($sformatf("steps_moved got %0d want %0d", steps, want.steps_moved));
         if (at !== want.at_target)
            report_mismatch($sformatf("at_target got %b want %b", at, want.at_target));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic                    csr_index = 1'b0;
   logic                    csr_data = 1'b0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_type = 1'b0;
   logic signed [POS_W-1:0] req_target_position = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [3:0]              rsp_coil_pattern;
   logic signed [POS_W-1:0] rsp_position;
   logic [2:0]              rsp_steps_moved;
   logic                    rsp_at_target;

   motion_tracker tracker = new(MAX_STEPS);
   int unsigned   burst_left = 0;
   int unsigned   stall_style = 0;
   int unsigned   stall_count = 0;

   stepper_position_sequencer #(.MAX_BURST(MAX_STEPS)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_coil_pattern    (rsp_coil_pattern),
      .rsp_position        (rsp_position),
      .rsp_steps_moved     (rsp_steps_moved),
      .rsp_at_target       (rsp_at_target)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_count == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_count <= $urandom_range(50, 300);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_style)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         2: begin
            rsp_stall <= ((stall_count % 9) < 6);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_coil_pattern, rsp_position, rsp_steps_moved, rsp_at_target);
   end

   task send_item(req_code_type kind, logic signed [POS_W-1:0] tgt);
      req_valid <= 1'b1;
      req_type <= kind;
      req_target_position <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_request(kind, tgt);
   endtask

   task pace(bit bursty);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = (!bursty || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task settle();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_settings(logic rev, logic half);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_REVERSE_DIRECTION;
      csr_data <= rev;
      @(posedge clock);
      csr_index <= CSR_HALF_STEP_MODE;
      csr_data <= half;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_reg(CSR_REVERSE_DIRECTION, rev);
      tracker.set_reg(CSR_HALF_STEP_MODE, half);
   endtask

   task random_item();
      int unsigned pick;
      int          offset;
      int          goal;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         send_item(REQ_TICK, POS_W'($urandom()));
         return;
      end
      if (pick < 75) begin
         offset = $urandom_range(0, 8);
      end else if (pick < 88) begin
         offset = $urandom_range(0, 700);
      end else if (pick < 95) begin
         offset = $urandom_range(0, 1);
      end else begin
         send_item(REQ_SET_TARGET, POS_W'($urandom()));
         return;
      end
      if ($urandom_range(0, 1) == 1) offset = -offset;
      goal = int'(tracker.position) + offset;
      if (goal > 8388607) goal = 8388607;
      if (goal < -8388608) goal = -8388608;
      send_item(REQ_SET_TARGET, POS_W'(goal));
   endtask

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic rev;
      logic half;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // released coils at reset, single steps, extremes, burst sizes
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 1);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, -1);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 24'sh7FFFFF);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 24'sh800000);
      send_item(REQ_TICK, 24'sh7FFFFF);
      send_item(REQ_SET_TARGET, 300);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 700);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 450);
      send_item(REQ_TICK, 0);
      send_item(REQ_SET_TARGET, 10);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      send_item(REQ_TICK, 0);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin rev = 1'b0; half = 1'b1; end
            1: begin rev = 1'b1; half = 1'b1; end
            2: begin rev = 1'b0; half = 1'b0; end
            3: begin rev = 1'b1; half = 1'b0; end
            default: begin
               rev = 1'($urandom_range(0, 1));
               half = 1'($urandom_range(0, 1));
            end
         endcase
         write_settings(rev, half);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pace(phase != 2);
            random_item();
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (tracker.pending.size() != 0)
         tracker.report_mismatch("ticks left without a response");
      if (tracker.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
